### hdl/sirdx_pkg.sv
// Shared constants and types for the signed integer to radix digit converter.
// No dependencies; every other file of the block refers to it by scoped names.
package sirdx_pkg;

  // Alphabet limits and field widths
  localparam int MAX_BASE    = 16;
  localparam int SYM_COUNT   = 16;
  localparam int CHAR_W      = 8;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;
  localparam int VALUE_W     = 32;
  localparam int MAG_W       = 33;
  localparam int MAX_DIGITS  = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  // Default depth of the request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Characters that may not appear in the alphabet, and the sign character
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_COUNT  = 2'd2;

  // One queued request: sign and 33-bit magnitude
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } qent_t;

  // Alphabet as seen by the back end
  typedef struct packed {
    logic [SYM_COUNT*CHAR_W-1:0] symbols;
    logic [RADIX_W-1:0]          radix;
  } alpha_t;

endpackage

### hdl/sirdx_front.sv
// Front end: configuration registers, alphabet check, sign and magnitude split.
// Depends on sirdx_pkg; pushes requests into sirdx_queue.
module sirdx_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sirdx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sirdx_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sirdx_pkg::VALUE_W-1:0] in_value,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output sirdx_pkg::qent_t                     push_entry,
  output sirdx_pkg::alpha_t                    alpha
);

  localparam int RW = sirdx_pkg::RADIX_W;
  localparam int CW = sirdx_pkg::CHAR_W;
  localparam int MW = sirdx_pkg::MAG_W;
  localparam int NS = sirdx_pkg::SYM_COUNT;

  logic [sirdx_pkg::CFG_DATA_W-1:0] sym_low_r,  sym_low_nxt;
  logic [sirdx_pkg::CFG_DATA_W-1:0] sym_high_r, sym_high_nxt;
  logic [RW-1:0]                    radix_r,    radix_nxt;
  logic [NS*CW-1:0]                 all_sym;
  logic [CW-1:0]                    sym [NS];
  logic                             alpha_ok;
  logic [MW-1:0]                    mag_ext;

  // Take register writes at any time
  assign cfg_ready = 1'b1;

  always_comb begin
    sym_low_nxt  = sym_low_r;
    sym_high_nxt = sym_high_r;
    radix_nxt    = radix_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        sirdx_pkg::REG_SYMBOLS_LOW:  sym_low_nxt  = cfg_data;
        sirdx_pkg::REG_SYMBOLS_HIGH: sym_high_nxt = cfg_data;
        sirdx_pkg::REG_RADIX_COUNT:  radix_nxt    = cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_low_r  <= '0;
      sym_high_r <= '0;
      radix_r    <= '0;
    end else begin
      sym_low_r  <= sym_low_nxt;
      sym_high_r <= sym_high_nxt;
      radix_r    <= radix_nxt;
    end
  end

  // Split the alphabet into symbol bytes
  assign all_sym = {sym_high_r, sym_low_r};

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      sym[i] = all_sym[i*CW +: CW];
    end
  end

  // Check range, reserved characters and duplicates among the symbols in use
  always_comb begin
    alpha_ok = (radix_r >= RW'(2)) && (radix_r <= RW'(sirdx_pkg::MAX_BASE));
    for (int i = 0; i < NS; i++) begin
      if (RW'(i) < radix_r) begin
        if (sym[i] == sirdx_pkg::CHAR_PLUS || sym[i] == sirdx_pkg::CHAR_MINUS ||
            sym[i] == sirdx_pkg::CHAR_SPACE) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < NS; j++) begin
          if (RW'(j) < radix_r && sym[i] == sym[j]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  assign alpha.symbols = all_sym;
  assign alpha.radix   = radix_r;

  // Accept whenever the queue has room; drop requests under a bad alphabet
  assign in_ready   = push_ready;
  assign push_valid = in_valid && alpha_ok;

  // Form the magnitude in 33 bits so the most negative value survives
  assign mag_ext          = {in_value[sirdx_pkg::VALUE_W-1], in_value};
  assign push_entry.neg   = in_value[sirdx_pkg::VALUE_W-1];
  assign push_entry.mag   = push_entry.neg ? (~mag_ext + MW'(1)) : mag_ext;

endmodule

### hdl/sirdx_queue.sv
// Short request queue between the front end and the digit generator.
// Depends on sirdx_pkg for the entry type.
module sirdx_queue #(
  parameter int DEPTH = sirdx_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  sirdx_pkg::qent_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sirdx_pkg::qent_t pop_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sirdx_pkg::qent_t mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r,  count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = mem_r[rd_ptr_r];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### hdl/sirdx_back.sv
// Back end: iterative division by the radix, digit buffer and character output.
// Depends on sirdx_pkg; pops requests from sirdx_queue.
module sirdx_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  sirdx_pkg::qent_t              pop_entry,
  input  sirdx_pkg::alpha_t             alpha,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sirdx_pkg::CHAR_W-1:0]  out_character,
  output logic                          out_last
);

  localparam int RW       = sirdx_pkg::RADIX_W;
  localparam int DW       = sirdx_pkg::DIGIT_W;
  localparam int CW       = sirdx_pkg::CHAR_W;
  localparam int MW       = sirdx_pkg::MAG_W;
  localparam int ND       = sirdx_pkg::MAX_DIGITS;
  localparam int BPC      = 8;                       // dividend bits per cycle
  localparam int DIV_CYC  = (MW + BPC - 1) / BPC;
  localparam int SH_W     = DIV_CYC * BPC;
  localparam int CYC_W    = $clog2(DIV_CYC);
  localparam int NDIG_W   = $clog2(ND + 1);
  localparam int IDX_W    = $clog2(ND);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_r,     state_nxt;
  logic [SH_W-1:0]   sh_r,        sh_nxt;
  logic [RW-1:0]     rem_r,       rem_nxt;
  logic [CYC_W-1:0]  cyc_r,       cyc_nxt;
  logic [NDIG_W-1:0] ndig_r,      ndig_nxt;
  logic              sign_r,      sign_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CW-1:0]     out_char_r,  out_char_nxt;
  logic              out_last_r,  out_last_nxt;
  logic [DW-1:0]     digits_r [ND];
  logic              dig_we;
  logic [SH_W-1:0]   sh_step;
  logic [RW-1:0]     rem_step;
  logic              can_load;
  logic [NDIG_W-1:0] ndig_m1;
  logic [DW-1:0]     rd_digit;

  // Restoring division, several quotient bits per cycle on a narrow remainder
  always_comb begin
    logic [RW-1:0]   r;
    logic [SH_W-1:0] s;
    logic            q;
    r = rem_r;
    s = sh_r;
    for (int k = 0; k < BPC; k++) begin
      r = {r[RW-2:0], s[SH_W-1]};
      q = (r >= alpha.radix);
      if (q) begin
        r = r - alpha.radix;
      end
      s = {s[SH_W-2:0], q};
    end
    rem_step = r;
    sh_step  = s;
  end

  assign can_load  = !out_valid_r || out_ready;
  assign ndig_m1   = ndig_r - NDIG_W'(1);
  assign rd_digit  = digits_r[ndig_m1[IDX_W-1:0]];
  assign pop_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    cyc_nxt       = cyc_r;
    ndig_nxt      = ndig_r;
    sign_nxt      = sign_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dig_we        = 1'b0;
    unique case (state_r)
      // Load the next request
      ST_IDLE: begin
        if (pop_valid) begin
          sh_nxt    = {{(SH_W - MW){1'b0}}, pop_entry.mag};
          rem_nxt   = '0;
          cyc_nxt   = '0;
          ndig_nxt  = '0;
          sign_nxt  = pop_entry.neg;
          state_nxt = ST_DIV;
        end
      end
      // Produce digits least significant first, one per full pass over the dividend
      ST_DIV: begin
        sh_nxt  = sh_step;
        rem_nxt = rem_step;
        cyc_nxt = cyc_r + CYC_W'(1);
        if (cyc_r == CYC_W'(DIV_CYC - 1)) begin
          dig_we   = 1'b1;
          ndig_nxt = ndig_r + NDIG_W'(1);
          rem_nxt  = '0;
          cyc_nxt  = '0;
          if (sh_step == '0 || ndig_nxt == NDIG_W'(ND)) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      // Send the sign, then digits most significant first
      ST_EMIT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          if (sign_r) begin
            out_char_nxt = sirdx_pkg::CHAR_MINUS;
            out_last_nxt = 1'b0;
            sign_nxt     = 1'b0;
          end else begin
            out_char_nxt = alpha.symbols[{rd_digit, 3'b000} +: CW];
            out_last_nxt = (ndig_r == NDIG_W'(1));
            ndig_nxt     = ndig_m1;
            if (ndig_r == NDIG_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cyc_r       <= '0;
      ndig_r      <= '0;
      sign_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cyc_r       <= cyc_nxt;
      ndig_r      <= ndig_nxt;
      sign_r      <= sign_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers and digit buffer
  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (dig_we) begin
      digits_r[ndig_r[IDX_W-1:0]] <= rem_step[DW-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

### hdl/signed_integer_to_radix_digits.sv
// Top level of the signed integer to radix digit converter.
// Depends on sirdx_pkg, sirdx_front, sirdx_queue and sirdx_back.

// Converts a signed 32-bit value into characters of a configured alphabet of
// 2 to 16 symbols (registers: 0 symbols 0..7, 1 symbols 8..15, 2 symbol count).
// A '-' leads a negative value, digits follow most significant first, and the
// final character carries out_last. Values arriving while the alphabet is
// invalid (too few or too many symbols, a '+', '-' or space, or a repeated
// symbol) are accepted and produce nothing. Requests wait in a short queue
// while the digit generator works. For each digit the divider makes one full
// pass over the 33-bit magnitude (8 quotient bits per cycle), and the
// characters leave at one per cycle while out_ready is high.
module signed_integer_to_radix_digits #(
  parameter int QUEUE_DEPTH = sirdx_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sirdx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sirdx_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sirdx_pkg::VALUE_W-1:0] in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sirdx_pkg::CHAR_W-1:0]         out_character,
  output logic                                 out_last
);

  logic              push_valid, push_ready;
  logic              pop_valid,  pop_ready;
  sirdx_pkg::qent_t  push_entry, pop_entry;
  sirdx_pkg::alpha_t alpha;

  sirdx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .alpha      (alpha)
  );

  sirdx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  sirdx_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_entry     (pop_entry),
    .alpha         (alpha),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

`ifndef SYNTH
  // The sign never ends a value
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == sirdx_pkg::CHAR_MINUS |-> !out_last)
    else $error("minus sign marked as last character");

  // Hold a stalled character steady until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("stalled output character changed");

  // A request leaves the queue only when at most the last character of the previous value is still pending
  a_pop_no_pending_digits: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid && pop_ready |=> !out_valid || out_last)
    else $error("new request started while digits were still pending");
`endif

endmodule
